// ===== rtl/bhdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bhdc_pkg
// Types and constants shared by the button hold duration classifier.
// ----------------------------------------------------------------------------
package bhdc_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned EVENT_W   = 3;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              pressed;
        logic              link_active;
    } t_in_item;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic               warn_first;
        logic               warn_second;
        logic [TIME_W-1:0]  held_time;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] grace_time;
        logic [CFG_W-1:0] stuck_timeout;
        logic [CFG_W-1:0] tap_minimum;
        logic [CFG_W-1:0] first_warn_time;
        logic [CFG_W-1:0] first_erase_time;
        logic [CFG_W-1:0] second_warn_time;
        logic [CFG_W-1:0] second_erase_time;
    } t_cfg;

    localparam logic [CFG_IDX_W-1:0] REG_GRACE_TIME        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STUCK_TIMEOUT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_MINIMUM       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_WARN_TIME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ERASE_TIME  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_WARN_TIME  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_ERASE_TIME = 3'd6;

    localparam logic [CFG_W-1:0] RST_GRACE_TIME        = 16'd3500;
    localparam logic [CFG_W-1:0] RST_STUCK_TIMEOUT     = 16'd2000;
    localparam logic [CFG_W-1:0] RST_TAP_MINIMUM       = 16'd50;
    localparam logic [CFG_W-1:0] RST_FIRST_WARN_TIME   = 16'd9000;
    localparam logic [CFG_W-1:0] RST_FIRST_ERASE_TIME  = 16'd10000;
    localparam logic [CFG_W-1:0] RST_SECOND_WARN_TIME  = 16'd14000;
    localparam logic [CFG_W-1:0] RST_SECOND_ERASE_TIME = 16'd15000;

    localparam logic [EVENT_W-1:0] EV_NONE         = 3'd0;
    localparam logic [EVENT_W-1:0] EV_TAP          = 3'd1;
    localparam logic [EVENT_W-1:0] EV_FIRST_ERASE  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_SECOND_ERASE = 3'd3;
    localparam logic [EVENT_W-1:0] EV_FIRST_SKIP   = 3'd4;
    localparam logic [EVENT_W-1:0] EV_SECOND_SKIP  = 3'd5;
    localparam logic [EVENT_W-1:0] EV_LATE_RELEASE = 3'd6;
    localparam logic [EVENT_W-1:0] EV_STUCK        = 3'd7;

endpackage

// ===== rtl/bhdc_cfg.sv =====
// ----------------------------------------------------------------------------
// bhdc_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bhdc_cfg
    import bhdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_cfg_ready,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grace_time        <= RST_GRACE_TIME;
            r_cfg.stuck_timeout     <= RST_STUCK_TIMEOUT;
            r_cfg.tap_minimum       <= RST_TAP_MINIMUM;
            r_cfg.first_warn_time   <= RST_FIRST_WARN_TIME;
            r_cfg.first_erase_time  <= RST_FIRST_ERASE_TIME;
            r_cfg.second_warn_time  <= RST_SECOND_WARN_TIME;
            r_cfg.second_erase_time <= RST_SECOND_ERASE_TIME;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GRACE_TIME:        r_cfg.grace_time        <= i_cfg_data;
                REG_STUCK_TIMEOUT:     r_cfg.stuck_timeout     <= i_cfg_data;
                REG_TAP_MINIMUM:       r_cfg.tap_minimum       <= i_cfg_data;
                REG_FIRST_WARN_TIME:   r_cfg.first_warn_time   <= i_cfg_data;
                REG_FIRST_ERASE_TIME:  r_cfg.first_erase_time  <= i_cfg_data;
                REG_SECOND_WARN_TIME:  r_cfg.second_warn_time  <= i_cfg_data;
                REG_SECOND_ERASE_TIME: r_cfg.second_erase_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/bhdc_core.sv =====
// ----------------------------------------------------------------------------
// bhdc_core
// Hold-state registers and single-pass classification of one poll.
// ----------------------------------------------------------------------------
module bhdc_core
    import bhdc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_res
);

    logic              r_armed, n_armed;
    logic              r_release_seen, n_release_seen;
    logic              r_last_level, n_last_level;
    logic              r_long_done, n_long_done;
    logic [TIME_W-1:0] r_press_start, n_press_start;
    logic              r_first_warned, n_first_warned;
    logic              r_second_warned, n_second_warned;

    logic [CFG_W:0]    stuck_limit;
    logic [TIME_W-1:0] held;
    t_out_item         res;

    assign stuck_limit = {1'b0, i_cfg.grace_time} + {1'b0, i_cfg.stuck_timeout};
    assign held        = i_item.now_ms - r_press_start;

    always_comb begin
        n_armed         = r_armed;
        n_release_seen  = r_release_seen;
        n_last_level    = r_last_level;
        n_long_done     = r_long_done;
        n_press_start   = r_press_start;
        n_first_warned  = r_first_warned;
        n_second_warned = r_second_warned;
        res             = '0;

        if (i_item.now_ms < TIME_W'(i_cfg.grace_time)) begin
            res = '0;
        end else if (!r_armed) begin
            n_last_level   = i_item.pressed;
            n_release_seen = !i_item.pressed;
            n_armed        = 1'b1;
        end else if (!r_release_seen) begin
            if (!i_item.pressed) begin
                n_release_seen = 1'b1;
                n_last_level   = 1'b0;
            end else if (i_item.now_ms >= TIME_W'(stuck_limit)) begin
                n_release_seen = 1'b1;
                n_last_level   = 1'b1;
                res.event_res  = EV_STUCK;
            end
        end else if (i_item.pressed && !r_last_level) begin
            n_press_start   = i_item.now_ms;
            n_long_done     = 1'b0;
            n_first_warned  = 1'b0;
            n_second_warned = 1'b0;
            n_last_level    = 1'b1;
        end else if (i_item.pressed && r_last_level && !r_long_done
                     && (r_press_start != '0)) begin
            if (held >= TIME_W'(i_cfg.first_warn_time)
                && held < TIME_W'(i_cfg.first_erase_time) && !r_first_warned) begin
                n_first_warned = 1'b1;
                res.warn_first = 1'b1;
            end
            if (held >= TIME_W'(i_cfg.second_warn_time)
                && held < TIME_W'(i_cfg.second_erase_time) && !r_second_warned) begin
                n_second_warned = 1'b1;
                res.warn_second = 1'b1;
            end
            if (held >= TIME_W'(i_cfg.second_erase_time)) begin
                n_long_done   = 1'b1;
                res.event_res = i_item.link_active ? EV_SECOND_SKIP : EV_SECOND_ERASE;
            end else if (held >= TIME_W'(i_cfg.first_erase_time)) begin
                n_long_done   = 1'b1;
                res.event_res = i_item.link_active ? EV_FIRST_SKIP : EV_FIRST_ERASE;
            end
        end else if (!i_item.pressed && r_last_level && !r_long_done) begin
            n_last_level = 1'b0;
            if (held >= TIME_W'(i_cfg.tap_minimum)
                && held < TIME_W'(i_cfg.first_erase_time)) begin
                res.event_res = EV_TAP;
                res.held_time = held;
            end else if (held >= TIME_W'(i_cfg.first_erase_time)) begin
                res.event_res = EV_LATE_RELEASE;
                res.held_time = held;
            end
        end else begin
            n_last_level = i_item.pressed;
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed         <= 1'b0;
            r_release_seen  <= 1'b0;
            r_last_level    <= 1'b0;
            r_long_done     <= 1'b0;
            r_press_start   <= '0;
            r_first_warned  <= 1'b0;
            r_second_warned <= 1'b0;
        end else if (i_step) begin
            r_armed         <= n_armed;
            r_release_seen  <= n_release_seen;
            r_last_level    <= n_last_level;
            r_long_done     <= n_long_done;
            r_press_start   <= n_press_start;
            r_first_warned  <= n_first_warned;
            r_second_warned <= n_second_warned;
        end
    end

    a_release_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> !r_release_seen)
        else $error("release seen before arming");

    a_long_needs_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_release_seen |-> !r_long_done)
        else $error("erase latched before release seen");

    a_stuck_sets_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.event_res == EV_STUCK |=> r_release_seen && r_last_level)
        else $error("stuck event did not end the wait");

    a_held_only_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.held_time != '0
        |-> res.event_res == EV_TAP || res.event_res == EV_LATE_RELEASE)
        else $error("hold time reported without release event");

    a_release_clears_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (res.event_res == EV_TAP || res.event_res == EV_LATE_RELEASE)
        |=> !r_last_level)
        else $error("release event left level high");

endmodule

// ===== rtl/button_hold_duration_classifier.sv =====
// ----------------------------------------------------------------------------
// button_hold_duration_classifier
// Classifies button holds into taps, warnings, erase, skip, stuck and late-release reports.
//
//   channel  direction  handshake                  payload
//   input    in         i_valid / o_ready          i_in  (t_in_item)
//   result   out        o_valid / i_ready          o_out (t_out_item)
//   config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One poll per cycle is sustained while results are taken; a poll passes from
// the input register through classification into the result register.
// The classification and state update are one pass of compares, one 32-bit
// subtraction and a 17-bit addition between the input and result registers.
// A stalled result holds the result register; the input register still
// takes a new poll while the result register is being emptied.
// Synchronous reset restores register defaults and clears all hold state.
// ----------------------------------------------------------------------------
module button_hold_duration_classifier
    import bhdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_item             i_in,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_item            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      advance;
    t_cfg      cfg;
    t_out_item res;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    bhdc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    bhdc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

endmodule
